/* hw/rtl/ovu_pkg.sv */
package ovu_pkg;

    localparam int MAX_DIM_DEFAULT = 64;

    localparam int ELEM_W      = 16;
    localparam int ACC_W       = 32;
    localparam int ETA_W       = 16;
    localparam int PROD_W      = 64;
    localparam int IDX_OUT_W   = 6;
    localparam int FRAC_SHIFT  = 12;
    localparam int ETA_SHIFT   = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ETA_W-1:0] LEARNING_RATE_RESET = 16'd655;

    localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [PROD_W-1:0] S16_MAX = 64'sh0000_0000_0000_7FFF;
    localparam logic signed [PROD_W-1:0] S16_MIN = 64'shFFFF_FFFF_FFFF_8000;

    typedef enum logic [1:0] {
        MUL_MX = 2'd0,
        MUL_EY = 2'd1,
        MUL_YM = 2'd2,
        MUL_TD = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    en;
        mul_op_t op;
    } mul_ctl_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = $signed(v[ACC_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [ELEM_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [ELEM_W-1:0] r;
        if (v > S16_MAX)
        begin
            r = 16'sh7FFF;
        end
        else if (v < S16_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = $signed(v[ELEM_W-1:0]);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ovu_mul.sv */
module ovu_mul (
    input  logic                                  clk,
    input  ovu_pkg::mul_ctl_t                     ctl,
    input  logic signed [ovu_pkg::ELEM_W-1:0]     elem_m,
    input  logic signed [ovu_pkg::ELEM_W-1:0]     elem_x,
    input  logic signed [ovu_pkg::ACC_W-1:0]      acc_y,
    input  logic signed [ovu_pkg::ACC_W-1:0]      eta_y,
    input  logic signed [ovu_pkg::ACC_W-1:0]      diff,
    input  logic        [ovu_pkg::ETA_W-1:0]      eta,
    output logic signed [ovu_pkg::PROD_W-1:0]     prod_reg
);
    import ovu_pkg::*;

    logic signed [ACC_W-1:0]  opa;
    logic signed [ACC_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod_full;

    always_comb
    begin
        case (ctl.op)
            MUL_MX:
            begin
                opa = {{(ACC_W-ELEM_W){elem_m[ELEM_W-1]}}, elem_m};
                opb = {{(ACC_W-ELEM_W){elem_x[ELEM_W-1]}}, elem_x};
            end
            MUL_EY:
            begin
                opa = $signed({{(ACC_W-ETA_W){1'b0}}, eta});
                opb = acc_y;
            end
            MUL_YM:
            begin
                opa = acc_y;
                opb = {{(ACC_W-ELEM_W){elem_m[ELEM_W-1]}}, elem_m};
            end
            MUL_TD:
            begin
                opa = eta_y;
                opb = diff;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_full = opa * opb;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_full;
        end
    end

endmodule

/* hw/rtl/ovu_store.sv */
module ovu_store #(
    parameter int DEPTH  = ovu_pkg::MAX_DIM_DEFAULT,
    parameter int ADDR_W = 6
) (
    input  logic                                clk,
    input  ovu_pkg::store_ctl_t                 ctl,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic [ovu_pkg::IN_TDATA_W-1:0]      wr_data,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic [ovu_pkg::IN_TDATA_W-1:0]      rd_data_reg
);
    import ovu_pkg::*;

    logic [IN_TDATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/oja_vector_update.sv */
// Oja rule update for one weight vector. Each input beat carries a weight and an input
// element (signed Q4.12); s_tlast, or the MAX_DIM-th element, closes the vector. One
// signed 32x32 multiplier is shared by every product under a small sequencer, so an
// element is loaded as a product, then a saturating accumulate of y, and after
// the closing element the block forms eta*y and then takes each element through
// y*m, difference, eta*y*d and result; the result step waits while m_tready is low
// and an earlier result is still held. s_tready is high only while it waits for the
// next load beat. The registered result stage lets a new vector start loading while
// the final result still waits. The element stores are written during the vector
// before they are read, so they need no clearing after reset.
module oja_vector_update #(
    parameter int MAX_DIM = ovu_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ovu_pkg::ETA_W-1:0]             cfg_wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ovu_pkg::IN_TDATA_W-1:0]        s_tdata,   // weight_value, input_value
    input  logic                                  s_tlast,   // last_element
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ovu_pkg::OUT_TDATA_W-1:0]       m_tdata,   // updated_weight, element_index
    output logic                                  m_tlast    // last_in_run
);
    import ovu_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [7:0] {
        ST_LOAD = 8'b0000_0001,
        ST_ACC  = 8'b0000_0010,
        ST_EY   = 8'b0000_0100,
        ST_EYW  = 8'b0000_1000,
        ST_YMI  = 8'b0001_0000,
        ST_YM   = 8'b0010_0000,
        ST_TM   = 8'b0100_0000,
        ST_RES  = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [ACC_W-1:0]  y_reg, y_next;
    logic signed [ACC_W-1:0]  ey_reg, ey_next;
    logic signed [ACC_W-1:0]  d_reg, d_next;
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         emit_reg, emit_next;
    logic                     vec_end_reg, vec_end_next;
    logic [ETA_W-1:0]         eta_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ELEM_W-1:0] out_weight_reg, out_weight_next;
    logic [IDX_OUT_W-1:0]     out_idx_reg, out_idx_next;
    logic                     out_last_reg, out_last_next;

    logic                     load_fire;
    logic                     out_load;
    logic                     emit_done;
    mul_ctl_t                 mul_ctl;
    store_ctl_t               store_ctl;
    logic [IDX_W-1:0]         rd_addr;
    logic [IN_TDATA_W-1:0]    rd_data_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_q12;
    logic signed [PROD_W-1:0] prod_q16;
    logic signed [ELEM_W-1:0] s_m, s_x, rd_m, rd_x, elem_m;
    logic signed [PROD_W-1:0] y_ext, x_ext, m_ext, ym_ext, t_ext;
    logic signed [ACC_W-1:0]  ym, t_val;

    assign s_m  = $signed(s_tdata[ELEM_W-1:0]);
    assign s_x  = $signed(s_tdata[2*ELEM_W-1:ELEM_W]);
    assign rd_m = $signed(rd_data_reg[ELEM_W-1:0]);
    assign rd_x = $signed(rd_data_reg[2*ELEM_W-1:ELEM_W]);

    assign s_tready  = (state_reg == ST_LOAD);
    assign load_fire = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_RES) && (!out_valid_reg || m_tready);
    assign emit_done = (emit_reg == cnt_reg);

    assign elem_m  = (state_reg == ST_LOAD) ? s_m : rd_m;
    assign rd_addr = (state_reg == ST_RES) ? (emit_reg + IDX_W'(1)) : emit_reg;

    assign prod_q12 = prod_reg >>> FRAC_SHIFT;
    assign prod_q16 = prod_reg >>> ETA_SHIFT;
    assign y_ext    = {{(PROD_W-ACC_W){y_reg[ACC_W-1]}}, y_reg};
    assign x_ext    = {{(PROD_W-ELEM_W){rd_x[ELEM_W-1]}}, rd_x};
    assign m_ext    = {{(PROD_W-ELEM_W){rd_m[ELEM_W-1]}}, rd_m};
    assign ym       = sat32(prod_q12);
    assign ym_ext   = {{(PROD_W-ACC_W){ym[ACC_W-1]}}, ym};
    assign t_val    = sat32(prod_q12);
    assign t_ext    = {{(PROD_W-ACC_W){t_val[ACC_W-1]}}, t_val};

    always_comb
    begin
        mul_ctl.en      = 1'b0;
        mul_ctl.op      = MUL_MX;
        store_ctl.wr_en = load_fire;
        store_ctl.rd_en = 1'b0;
        state_next      = state_reg;
        y_next          = y_reg;
        ey_next         = ey_reg;
        d_next          = d_reg;
        cnt_next        = cnt_reg;
        emit_next       = emit_reg;
        vec_end_next    = vec_end_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_weight_next = out_weight_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    mul_ctl.en   = 1'b1;
                    mul_ctl.op   = MUL_MX;
                    vec_end_next = s_tlast || (cnt_reg == IDX_W'(MAX_DIM - 1));
                    state_next   = ST_ACC;
                end
            end
            ST_ACC:
            begin
                y_next = sat32(y_ext + prod_q12);
                if (vec_end_reg)
                begin
                    state_next = ST_EY;
                end
                else
                begin
                    cnt_next   = cnt_reg + IDX_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_EY:
            begin
                mul_ctl.en      = 1'b1;
                mul_ctl.op      = MUL_EY;
                store_ctl.rd_en = 1'b1;
                state_next      = ST_EYW;
            end
            ST_EYW:
            begin
                ey_next    = sat32(prod_q16);
                state_next = ST_YMI;
            end
            ST_YMI:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.op = MUL_YM;
                state_next = ST_YM;
            end
            ST_YM:
            begin
                d_next     = sat32(x_ext - ym_ext);
                state_next = ST_TM;
            end
            ST_TM:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.op = MUL_TD;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_weight_next = sat16(m_ext + t_ext);
                    out_idx_next    = IDX_OUT_W'(emit_reg);
                    out_last_next   = emit_done;
                    if (emit_done)
                    begin
                        y_next     = '0;
                        cnt_next   = '0;
                        emit_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        store_ctl.rd_en = 1'b1;
                        emit_next       = emit_reg + IDX_W'(1);
                        state_next      = ST_YMI;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            y_reg         <= '0;
            cnt_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            eta_reg       <= LEARNING_RATE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            y_reg         <= y_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                eta_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ey_reg         <= ey_next;
        d_reg          <= d_next;
        vec_end_reg    <= vec_end_next;
        out_weight_reg <= out_weight_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
    end

    ovu_mul u_mul (
        .clk      (clk),
        .ctl      (mul_ctl),
        .elem_m   (elem_m),
        .elem_x   (s_x),
        .acc_y    (y_reg),
        .eta_y    (ey_reg),
        .diff     (d_reg),
        .eta      (eta_reg),
        .prod_reg (prod_reg)
    );

    ovu_store #(
        .DEPTH  (MAX_DIM),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk         (clk),
        .ctl         (store_ctl),
        .wr_addr     (cnt_reg),
        .wr_data     (s_tdata),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data_reg)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_idx_reg, out_weight_reg});
    assign m_tlast  = out_last_reg;

    // emission never runs past the stored length
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD && state_reg != ST_ACC) |-> (emit_reg <= cnt_reg))
        else $error("emission index beyond vector length");

    // clear the vector state once the final result is loaded
    a_vec_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_done) |=> (state_reg == ST_LOAD && cnt_reg == '0 && y_reg == '0))
        else $error("vector state not cleared after final result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (emit_reg == '0))
        else $error("emission index left set while loading");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cnt_reg) <= MAX_DIM - 1))
        else $error("element count beyond MAX_DIM");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_OUT_W+ELEM_W-1:ELEM_W] ==
            $past(IDX_OUT_W'(cnt_reg))) || $stable(m_tdata) || !$rose(m_tvalid))
        else $error("last beat index does not match vector length");

endmodule
